>>> design/lvps_pkg.sv
// Shared types and constants for the lattice Viterbi path selector.
`timescale 1ns / 1ps

package lvps_pkg;

  localparam int unsigned MAX_CANDIDATES_DEF = 16;
  localparam int unsigned MAX_COLUMNS_DEF    = 64;
  localparam int unsigned NUM_CLASSES_DEF    = 256;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SCORE_W   = 48;
  localparam int unsigned SUM_W     = 50;
  localparam int unsigned CLS_IN_W  = 8;
  localparam int unsigned CLS_CODES = 256;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 48'sh8000_0000_0000;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_NODE = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [CLS_IN_W-1:0]        from_class;
    logic [CLS_IN_W-1:0]        to_class;
    logic signed [VAL_W-1:0]    trans_value;
    logic signed [VAL_W-1:0]    node_weight;
    logic [CLS_IN_W-1:0]        node_class;
    logic                       new_column;
    logic                       lattice_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0] column_index;
    logic [3:0] selected_index;
    logic       overflow_error;
    logic       last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_WRITE,
    ST_BT_START,
    ST_BT_WAIT,
    ST_BT_NEXT
  } state_t;

endpackage

>>> design/lattice_viterbi_path_selector_unit.sv
// Viterbi path selector over a lattice of candidate columns, one shared add-compare unit.
`timescale 1ns / 1ps

// A word with req_type LOAD writes one transition score into the class-pair table. A
// node word is scored against each node of the previous column, which holds at most
// MAX_CANDIDATES nodes; a node in column 0 or a dropped node has no scan. One
// add-saturate-compare unit walks the previous column once per cycle, behind a
// score-bank read and a table read, and the pipeline drains before the node is written.
// A node that ends the lattice then runs a backtrace that returns one word per column,
// last column first, through the back-pointer memory. in_ready is high only between
// words. The last result word of a backtrace may still wait at the output while the
// next input word is taken. Path scores are Q16.16 held in 48 bits and saturate.
module lattice_viterbi_path_selector_unit #(
  parameter int unsigned MAX_CANDIDATES = lvps_pkg::MAX_CANDIDATES_DEF,
  parameter int unsigned MAX_COLUMNS    = lvps_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned NUM_CLASSES    = lvps_pkg::NUM_CLASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lvps_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lvps_pkg::out_word_t out_data
);
  import lvps_pkg::*;

  localparam int unsigned CLS_W     = $clog2(NUM_CLASSES);
  localparam int unsigned TBL_DEPTH = NUM_CLASSES * NUM_CLASSES;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned CAND_W    = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned NODE_AW   = CAND_W + 1;
  localparam int unsigned NODE_DW   = SCORE_W + CLS_W;
  localparam int unsigned COL_W     = $clog2(MAX_COLUMNS + 2);
  localparam int unsigned COLI_W    = $clog2(MAX_COLUMNS);
  localparam int unsigned BP_DEPTH  = MAX_COLUMNS * MAX_CANDIDATES;
  localparam int unsigned BP_AW     = $clog2(BP_DEPTH);

  // class code wrap, modulo NUM_CLASSES
  logic [CLS_W-1:0] cls_wrap [CLS_CODES];
  for (genvar g = 0; g < CLS_CODES; g++) begin : g_wrap
    assign cls_wrap[g] = CLS_W'(g % NUM_CLASSES);
  end

  // memories
  logic [VAL_W-1:0]   tbl_mem  [TBL_DEPTH];
  logic [NODE_DW-1:0] node_mem [2 * MAX_CANDIDATES];
  logic [CAND_W-1:0]  bp_mem   [BP_DEPTH];

  logic [VAL_W-1:0]   tbl_rd_r;
  logic [NODE_DW-1:0] node_rd_r;
  logic [CAND_W-1:0]  bp_rd_r;

  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  logic [BP_AW-1:0]   bp_waddr, bp_raddr;
  logic               tbl_we, node_we, bp_we;

  // control and datapath registers
  state_t                     state_r, state_nxt;
  in_word_t                   item_r, item_nxt;
  logic [CLS_W-1:0]           cls_r, cls_nxt;
  logic [COL_W-1:0]           col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0]           prev_cnt_r, prev_cnt_nxt;
  logic [CNT_W-1:0]           cur_cnt_r, cur_cnt_nxt;
  logic                       err_r, err_nxt;
  logic                       bank_r, bank_nxt;
  logic [CNT_W-1:0]           iss_j_r, iss_j_nxt;
  logic                       p1_vld_r, p1_vld_nxt;
  logic [CAND_W-1:0]          p1_j_r, p1_j_nxt;
  logic                       p2_vld_r, p2_vld_nxt;
  logic [CAND_W-1:0]          p2_j_r, p2_j_nxt;
  logic signed [SCORE_W-1:0]  p2_score_r, p2_score_nxt;
  logic                       p3_vld_r, p3_vld_nxt;
  logic [CAND_W-1:0]          p3_j_r, p3_j_nxt;
  logic signed [SCORE_W-1:0]  p3_sum_r, p3_sum_nxt;
  logic signed [SCORE_W-1:0]  best_r, best_nxt;
  logic [CAND_W-1:0]          bj_r, bj_nxt;
  logic [COLI_W-1:0]          bt_col_r, bt_col_nxt;
  logic [CAND_W-1:0]          bt_best_r, bt_best_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_word_t                  out_data_r, out_data_nxt;

  // combinational helpers
  logic signed [SCORE_W-1:0]  weight_ext;
  logic [SUM_W-1:0]           sum_w;
  logic signed [SCORE_W-1:0]  sum_sat;
  logic [COLI_W-1:0]          col_idx;
  logic [COL_W-1:0]           bt_cols;
  logic                       need_scan, issuing, slot_free, drop;
  logic                       ld;
  logic [COLI_W-1:0]          ld_col;
  logic [CAND_W-1:0]          ld_best;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign weight_ext = {{(SCORE_W - VAL_W){item_r.node_weight[VAL_W-1]}}, item_r.node_weight};
  assign col_idx    = COLI_W'(col_cnt_r - COL_W'(1));
  assign bt_cols    = (col_cnt_r > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : col_cnt_r;
  assign slot_free  = !out_valid_r || out_ready;
  assign need_scan  = (col_cnt_r > COL_W'(1)) && (prev_cnt_r != '0);
  assign issuing    = need_scan && (iss_j_r != prev_cnt_r);

  // memory addressing
  assign tbl_waddr  = TBL_AW'(TBL_AW'(cls_wrap[item_r.from_class]) * TBL_AW'(NUM_CLASSES))
                    + TBL_AW'(cls_wrap[item_r.to_class]);
  assign tbl_raddr  = TBL_AW'(TBL_AW'(node_rd_r[CLS_W-1:0]) * TBL_AW'(NUM_CLASSES))
                    + TBL_AW'(cls_r);
  assign node_waddr = {bank_r, cur_cnt_r[CAND_W-1:0]};
  assign node_raddr = {~bank_r, iss_j_r[CAND_W-1:0]};
  assign bp_waddr   = BP_AW'(BP_AW'(col_idx) * BP_AW'(MAX_CANDIDATES))
                    + BP_AW'(cur_cnt_r[CAND_W-1:0]);
  assign bp_raddr   = BP_AW'(BP_AW'(bt_col_r) * BP_AW'(MAX_CANDIDATES)) + BP_AW'(bt_best_r);

  // shared add-saturate unit: prev score + transition + weight
  assign sum_w = {{(SUM_W - SCORE_W){p2_score_r[SCORE_W-1]}}, p2_score_r}
               + {{(SUM_W - VAL_W){tbl_rd_r[VAL_W-1]}}, tbl_rd_r}
               + {{(SUM_W - VAL_W){item_r.node_weight[VAL_W-1]}}, item_r.node_weight};

  always_comb begin
    if ((&sum_w[SUM_W-1:SCORE_W-1]) || !(|sum_w[SUM_W-1:SCORE_W-1])) begin
      sum_sat = $signed(sum_w[SCORE_W-1:0]);
    end else if (sum_w[SUM_W-1]) begin
      sum_sat = SCORE_MIN;
    end else begin
      sum_sat = SCORE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= item_r.trans_value;
    end
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= {best_r, cls_r};
    end
    node_rd_r <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= bj_r;
    end
    bp_rd_r <= bp_mem[bp_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_cnt_r   <= '0;
      prev_cnt_r  <= '0;
      cur_cnt_r   <= '0;
      err_r       <= 1'b0;
      bank_r      <= 1'b0;
      iss_j_r     <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_cnt_r   <= col_cnt_nxt;
      prev_cnt_r  <= prev_cnt_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      err_r       <= err_nxt;
      bank_r      <= bank_nxt;
      iss_j_r     <= iss_j_nxt;
      p1_vld_r    <= p1_vld_nxt;
      p2_vld_r    <= p2_vld_nxt;
      p3_vld_r    <= p3_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cls_r      <= cls_nxt;
    p1_j_r     <= p1_j_nxt;
    p2_j_r     <= p2_j_nxt;
    p2_score_r <= p2_score_nxt;
    p3_j_r     <= p3_j_nxt;
    p3_sum_r   <= p3_sum_nxt;
    best_r     <= best_nxt;
    bj_r       <= bj_nxt;
    bt_col_r   <= bt_col_nxt;
    bt_best_r  <= bt_best_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cls_nxt       = cls_r;
    col_cnt_nxt   = col_cnt_r;
    prev_cnt_nxt  = prev_cnt_r;
    cur_cnt_nxt   = cur_cnt_r;
    err_nxt       = err_r;
    bank_nxt      = bank_r;
    iss_j_nxt     = iss_j_r;
    p1_vld_nxt    = 1'b0;
    p1_j_nxt      = iss_j_r[CAND_W-1:0];
    p2_vld_nxt    = p1_vld_r;
    p2_j_nxt      = p1_j_r;
    p2_score_nxt  = $signed(node_rd_r[NODE_DW-1:CLS_W]);
    p3_vld_nxt    = p2_vld_r;
    p3_j_nxt      = p2_j_r;
    p3_sum_nxt    = sum_sat;
    best_nxt      = best_r;
    bj_nxt        = bj_r;
    bt_col_nxt    = bt_col_r;
    bt_best_nxt   = bt_best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    tbl_we        = 1'b0;
    node_we       = 1'b0;
    bp_we         = 1'b0;
    drop          = 1'b0;
    ld            = 1'b0;
    ld_col        = bt_col_r;
    ld_best       = bt_best_r;

    // compare stage; first candidate always takes, ties keep the earlier one
    if (p3_vld_r && ((p3_j_r == '0) || (p3_sum_r > best_r))) begin
      best_nxt = p3_sum_r;
      bj_nxt   = p3_j_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (item_r.req_type == REQ_LOAD) begin
          tbl_we    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cls_nxt = cls_wrap[item_r.node_class];
          if (item_r.new_column || (col_cnt_r == '0)) begin
            if (col_cnt_r >= COL_W'(MAX_COLUMNS)) begin
              col_cnt_nxt = COL_W'(MAX_COLUMNS + 1);
              err_nxt     = 1'b1;
              drop        = 1'b1;
            end else begin
              // the current bank becomes the previous column
              if (col_cnt_r != '0) begin
                prev_cnt_nxt = cur_cnt_r;
                bank_nxt     = ~bank_r;
              end
              cur_cnt_nxt = '0;
              col_cnt_nxt = col_cnt_r + COL_W'(1);
            end
          end else if (col_cnt_r > COL_W'(MAX_COLUMNS)) begin
            drop = 1'b1;
          end else if (cur_cnt_r >= CNT_W'(MAX_CANDIDATES)) begin
            err_nxt = 1'b1;
            drop    = 1'b1;
          end
          if (drop) begin
            state_nxt = item_r.lattice_end ? ST_BT_START : ST_IDLE;
          end else begin
            iss_j_nxt = '0;
            best_nxt  = weight_ext;
            bj_nxt    = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (issuing) begin
          p1_vld_nxt = 1'b1;
          iss_j_nxt  = iss_j_r + CNT_W'(1);
        end else if (!p1_vld_r && !p2_vld_r && !p3_vld_r) begin
          state_nxt = ST_WRITE;
        end
      end

      ST_WRITE: begin
        node_we     = 1'b1;
        bp_we       = 1'b1;
        cur_cnt_nxt = cur_cnt_r + CNT_W'(1);
        state_nxt   = item_r.lattice_end ? ST_BT_START : ST_IDLE;
      end

      ST_BT_START: begin
        if (bt_cols == '0) begin
          col_cnt_nxt  = '0;
          prev_cnt_nxt = '0;
          cur_cnt_nxt  = '0;
          err_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end else if (slot_free) begin
          ld      = 1'b1;
          ld_col  = COLI_W'(bt_cols - COL_W'(1));
          ld_best = '0;
        end
      end

      ST_BT_WAIT: begin
        // back-pointer read for the word just loaded is in flight
        state_nxt = ST_BT_NEXT;
      end

      ST_BT_NEXT: begin
        if (slot_free) begin
          ld      = 1'b1;
          ld_col  = bt_col_r - COLI_W'(1);
          ld_best = bp_rd_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ld) begin
      bt_col_nxt                  = ld_col;
      bt_best_nxt                 = ld_best;
      out_valid_nxt               = 1'b1;
      out_data_nxt.column_index   = 6'(ld_col);
      out_data_nxt.selected_index = 4'(ld_best);
      out_data_nxt.overflow_error = err_r;
      out_data_nxt.last_of_run    = (ld_col == '0);
      if (ld_col == '0) begin
        col_cnt_nxt  = '0;
        prev_cnt_nxt = '0;
        cur_cnt_nxt  = '0;
        err_nxt      = 1'b0;
        state_nxt    = ST_IDLE;
      end else begin
        state_nxt = ST_BT_WAIT;
      end
    end
  end

endmodule

>>> tb/lattice_viterbi_path_selector_unit_tb.sv
// Self-checking bench for the lattice Viterbi path selector: queued words, prediction, scoreboard.
`timescale 1ns / 1ps

module lattice_viterbi_path_selector_unit_tb;
  import lvps_pkg::*;

  localparam int unsigned NCAND       = MAX_CANDIDATES_DEF;
  localparam int unsigned NCOLS       = MAX_COLUMNS_DEF;
  localparam int unsigned PHASE_ITEMS = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned RUN_LIMIT   = 400000;
  localparam longint      PATH_HI     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      PATH_LO     = -PATH_HI - 1;

  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_SRC_GAP,
    MODE_SNK_STALL,
    MODE_BOTH
  } gap_mode_t;

  typedef struct {
    in_word_t  word;
    gap_mode_t mode;
    bit        hold;
    bit        drain;
  } stim_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;

  logic      in_fire   = 1'b0;
  logic      hold_kick = 1'b0;
  gap_mode_t idle_mode = MODE_FREE;
  int unsigned hold_left = 0;

  stim_t       stim_q[$];
  out_word_t   path_expect[$];
  byte unsigned cls_pool[$];
  gap_mode_t   gen_mode = MODE_FREE;
  bit          tag_hold  = 1'b0;
  bit          tag_drain = 1'b0;
  int unsigned n_items = 0;

  int unsigned fail_cnt      = 0;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned lattices_done = 0;
  int unsigned err_runs      = 0;

  // predictor state
  logic [31:0]        trans_mem [0:65535];
  logic signed [47:0] prev_sc [0:NCAND-1];
  logic signed [47:0] curr_sc [0:NCAND-1];
  logic [7:0]         prev_cl [0:NCAND-1];
  logic [7:0]         curr_cl [0:NCAND-1];
  logic [3:0]         bp_mem  [0:NCOLS*NCAND-1];
  int unsigned        n_cols = 0;
  int unsigned        n_prev = 0;
  int unsigned        n_curr = 0;
  bit                 run_err = 1'b0;

  always #1 clk = ~clk;

  lattice_viterbi_path_selector_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  function automatic longint clamp48(longint s);
    if (s > PATH_HI) return PATH_HI;
    if (s < PATH_LO) return PATH_LO;
    return s;
  endfunction

  function automatic void score_node(logic signed [31:0] wt, logic [7:0] cls, logic newc);
    int unsigned col, k, j, best_j;
    longint best, s;
    if (newc || n_cols == 0) begin
      if (n_cols >= NCOLS) begin
        n_cols  = NCOLS + 1;
        run_err = 1'b1;
        return;
      end
      if (n_cols > 0) begin
        for (j = 0; j < NCAND; j++) begin
          prev_sc[j] = curr_sc[j];
          prev_cl[j] = curr_cl[j];
        end
        n_prev = n_curr;
      end
      n_curr = 0;
      n_cols++;
    end else if (n_cols > NCOLS) begin
      return;
    end
    if (n_curr >= NCAND) begin
      run_err = 1'b1;
      return;
    end
    col    = n_cols - 1;
    k      = n_curr;
    best   = longint'(wt);
    best_j = 0;
    if (col > 0) begin
      for (j = 0; j < n_prev && j < NCAND; j++) begin
        s = longint'(prev_sc[j]) + longint'($signed(trans_mem[{prev_cl[j], cls}]))
            + longint'(wt);
        s = clamp48(s);
        // strict compare keeps the earliest node on a tie
        if (j == 0 || s > best) begin
          best   = s;
          best_j = j;
        end
      end
    end
    curr_sc[k] = best[47:0];
    curr_cl[k] = cls;
    bp_mem[col*NCAND + k] = best_j[3:0];
    n_curr = k + 1;
  endfunction

  function automatic void track_lattice(in_word_t w);
    int unsigned cols, col, pick, c;
    out_word_t r;
    if (w.req_type == REQ_LOAD) begin
      trans_mem[{w.from_class, w.to_class}] = w.trans_value;
      return;
    end
    score_node(w.node_weight, w.node_class, w.new_column);
    if (!w.lattice_end) return;
    cols = (n_cols > NCOLS) ? NCOLS : n_cols;
    pick = 0;
    // backtrace from node 0 of the last kept column
    for (c = cols; c > 0; c--) begin
      col = c - 1;
      r.column_index   = col[5:0];
      r.selected_index = pick[3:0];
      r.overflow_error = run_err;
      r.last_of_run    = (col == 0);
      path_expect.push_back(r);
      pick = 32'(bp_mem[col*NCAND + (pick % NCAND)]);
    end
    if (run_err) err_runs++;
    lattices_done++;
    n_cols  = 0;
    n_prev  = 0;
    n_curr  = 0;
    run_err = 1'b0;
  endfunction

  function automatic bit src_gap(gap_mode_t m);
    if (m == MODE_SRC_GAP) return $urandom_range(99) < 69;
    if (m == MODE_BOTH) return $urandom_range(99) < 8;
    return 1'b0;
  endfunction

  function automatic bit snk_stall(gap_mode_t m);
    if (m == MODE_SNK_STALL) return $urandom_range(99) < 69;
    if (m == MODE_BOTH) return $urandom_range(99) < 8;
    return 1'b0;
  endfunction

  function automatic void push_word(in_word_t w);
    stim_t s;
    s.word  = w;
    s.mode  = gen_mode;
    s.hold  = tag_hold;
    s.drain = tag_drain;
    tag_hold  = 1'b0;
    tag_drain = 1'b0;
    stim_q.push_back(s);
    n_items++;
  endfunction

  function automatic void push_load(logic [7:0] from_c, logic [7:0] to_c, logic [31:0] val);
    in_word_t w;
    w.req_type    = REQ_LOAD;
    w.from_class  = from_c;
    w.to_class    = to_c;
    w.trans_value = val;
    w.node_weight = $urandom();
    w.node_class  = 8'($urandom_range(255));
    w.new_column  = 1'($urandom_range(1));
    w.lattice_end = 1'($urandom_range(1));
    push_word(w);
  endfunction

  function automatic void push_node(logic [31:0] wt, logic [7:0] cls, logic nc, logic le);
    in_word_t w;
    w.req_type    = REQ_NODE;
    w.from_class  = 8'($urandom_range(255));
    w.to_class    = 8'($urandom_range(255));
    w.trans_value = $urandom();
    w.node_weight = wt;
    w.node_class  = cls;
    w.new_column  = nc;
    w.lattice_end = le;
    push_word(w);
  endfunction

  function automatic logic [31:0] rand_score();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_class();
    return cls_pool[$urandom_range(cls_pool.size() - 1)];
  endfunction

  // a class joins the pool only once every pair with the pool is loaded
  function automatic void add_class(logic [7:0] c);
    foreach (cls_pool[i]) if (cls_pool[i] == c) return;
    cls_pool.push_back(c);
    foreach (cls_pool[i]) begin
      push_load(c, cls_pool[i], rand_score());
      if (cls_pool[i] != c) push_load(cls_pool[i], c, rand_score());
    end
  endfunction

  function automatic void gen_lattice(int unsigned ncols, int unsigned minn, int unsigned maxn,
                                      bit open_bare, bit close);
    int unsigned nn;
    bit last;
    for (int unsigned c = 0; c < ncols; c++) begin
      nn = $urandom_range(maxn, minn);
      for (int unsigned k = 0; k < nn; k++) begin
        last = close && (c == ncols - 1) && (k == nn - 1);
        push_node(rand_score(), pick_class(), (k == 0) && !(c == 0 && open_bare), last);
      end
    end
  endfunction

  initial begin : stim_proc
    int unsigned start, r;
    cls_pool.push_back(8'h00);
    cls_pool.push_back(8'hFF);
    cls_pool.push_back(8'h5A);
    cls_pool.push_back(8'hA5);
    foreach (cls_pool[i]) foreach (cls_pool[j]) push_load(cls_pool[i], cls_pool[j], 32'h0);

    // tie in column 0, opening node without new_column
    push_node(32'd5, 8'h00, 1'b0, 1'b0);
    push_node(32'd5, 8'hFF, 1'b0, 1'b0);
    push_node(32'h7FFF_FFFF, 8'h5A, 1'b1, 1'b1);
    push_load(8'h00, 8'hA5, 32'h7FFF_FFFF);
    push_load(8'hFF, 8'hA5, 32'h8000_0000);
    // extreme weights and transitions over three columns
    push_node(32'h8000_0000, 8'h00, 1'b1, 1'b0);
    push_node(32'h7FFF_FFFF, 8'hFF, 1'b0, 1'b0);
    push_node(32'hFFFF_FFFF, 8'hA5, 1'b1, 1'b0);
    push_node(32'h0000_0000, 8'h5A, 1'b0, 1'b0);
    push_node(32'h7FFF_FFFF, 8'h00, 1'b1, 1'b1);
    // single-node lattice
    push_node(32'h0000_0000, 8'hA5, 1'b1, 1'b1);
    // best predecessor is the third node
    push_node(32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0);
    push_node(32'h0000_1000, 8'hFF, 1'b0, 1'b0);
    push_node(32'h7FFF_FFFF, 8'h5A, 1'b0, 1'b0);
    push_node(32'h8000_0000, 8'hA5, 1'b1, 1'b1);

    // full column scanned by a column that overflows; the final node is itself dropped
    for (int unsigned k = 0; k < NCAND; k++) begin
      push_node(rand_score(), pick_class(), k == 0, 1'b0);
    end
    for (int unsigned k = 0; k <= NCAND; k++) begin
      push_node(rand_score(), pick_class(), k == 0, k == NCAND);
    end

    for (int unsigned p = 0; p < 4; p++) begin
      gen_mode = gap_mode_t'(p);
      if (gen_mode == MODE_SRC_GAP) begin
        // output held off while the next words keep coming
        gen_mode = MODE_FREE;
        tag_hold = 1'b1;
        gen_lattice(4, 1, 2, 1'b0, 1'b1);
        gen_mode = MODE_SRC_GAP;
      end else if (gen_mode == MODE_SNK_STALL) begin
        // too many columns, final node lands in a dropped column
        gen_lattice(NCOLS + 2, 1, 1, 1'b0, 1'b1);
      end else if (gen_mode == MODE_BOTH) begin
        tag_drain = 1'b1;
        gen_lattice(3, 1, 4, 1'b0, 1'b1);
      end
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 15) begin
          push_load(pick_class(), pick_class(), rand_score());
        end else if (r < 22) begin
          push_load(8'($urandom_range(255)), 8'($urandom_range(255)), $urandom());
        end else if (r < 30 && cls_pool.size() < 6) begin
          add_class(8'($urandom_range(255)));
        end else if (r < 40) begin
          gen_lattice($urandom_range(2, 1), 1, 3, 1'b0, 1'b0);
        end else begin
          gen_lattice($urandom_range(3, 1), 1, 3, $urandom_range(3) == 0, 1'b1);
        end
      end
    end
    gen_lattice(2, 1, 3, 1'b0, 1'b1);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() != 0 || in_valid) @(negedge clk);
    while (path_expect.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (path_expect.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, path_expect.size());
      fail_cnt++;
    end
    $display("Run: %0d input words, %0d lattices, %0d backtrace words checked.",
             words_sent, lattices_done, results_seen);
    $display("Incl. %0d runs with column/candidate overflow, long output hold, drain pause.",
             err_runs);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cyc;
    for (cyc = 0; cyc < RUN_LIMIT; cyc++) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $time, RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin : drive_proc
    logic give;
    logic kick;
    give = in_valid && !in_fire;
    kick = 1'b0;
    if (!give && rst_n && stim_q.size() != 0) begin
      if (!(stim_q[0].drain && path_expect.size() != 0) && !src_gap(stim_q[0].mode)) begin
        in_data   <= stim_q[0].word;
        idle_mode <= stim_q[0].mode;
        kick       = stim_q[0].hold;
        give       = 1'b1;
        stim_q.delete(0);
        words_sent++;
      end
    end
    in_valid  <= give;
    hold_kick <= kick;
  end

  always @(negedge clk) begin : sink_proc
    if (hold_kick) hold_left = HOLD_CYCLES;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !snk_stall(idle_mode);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch_proc
    out_word_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (path_expect.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
          fail_cnt++;
        end else begin
          want = path_expect.pop_front();
          check_field("column_index", 8'(want.column_index), 8'(out_data.column_index));
          check_field("selected_index", 8'(want.selected_index),
                      8'(out_data.selected_index));
          check_field("overflow_error", 8'(want.overflow_error),
                      8'(out_data.overflow_error));
          check_field("last_of_run", 8'(want.last_of_run), 8'(out_data.last_of_run));
        end
      end
      if (in_valid && in_ready) track_lattice(in_data);
    end
  end

endmodule
